// ===== rtl/wacs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacs_pkg: shared types for the windowed acceleration statistics block
// Command and status structures passing between the controller and datapath.
// ----------------------------------------------------------------------------
package wacs_pkg;

	localparam logic [15:0] WINDOW_RESET = 16'd1000;

	typedef struct packed {
		logic start;
		logic write;
		logic expire_rd;
		logic expire_pop;
		logic scan_rd;
		logic scan_acc;
		logic scan_first;
		logic div_start;
		logic div_step;
		logic ov_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic expired;
		logic empty;
		logic scan_last;
		logic div_last;
	} sts_t;

endpackage

// ===== rtl/wacs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacs_ctrl: sequencer for one statistics step
// Walks the append, expiry, scan and division phases of one item.
// ----------------------------------------------------------------------------
module wacs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_busy,
	input  wacs_pkg::sts_t  sts,
	output wacs_pkg::cmd_t  cmd,
	output logic            idle
);
	import wacs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXRD = 3'd1;
	localparam logic [2:0] S_EXCK = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OV   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;
	localparam logic [2:0] S_DVST = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.start = 1'b1;
					cmd.write = 1'b1;
					state_d = S_EXRD;
				end
			end
			S_EXRD: begin
				cmd.expire_rd = 1'b1;
				state_d = S_EXCK;
			end
			S_EXCK: begin
				if (sts.empty) begin
					state_d = S_DIV;
					cmd.div_start = 1'b1;
				end else if (sts.expired) begin
					cmd.expire_pop = 1'b1;
					state_d = S_EXRD;
				end else begin
					cmd.scan_rd = 1'b1;
					cmd.scan_first = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_acc = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DVST;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_DVST: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_OV;
			end
			S_OV: begin
				cmd.ov_step = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign idle = (state_q == S_IDLE);
endmodule

// ===== rtl/wacs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacs_datapath: sample store, accumulators and dividers
// Holds the ring store, the running extremes and the restoring dividers.
// ----------------------------------------------------------------------------
module wacs_datapath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wacs_pkg::cmd_t     cmd,
	output wacs_pkg::sts_t     sts,
	input  logic [15:0]        window_ms,
	input  logic [31:0]        now_ms,
	input  logic               sample_present,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic signed [15:0] res_mean [3],
	output logic signed [15:0] res_max [3],
	output logic signed [15:0] res_min [3],
	output logic signed [15:0] res_peak,
	output logic signed [15:0] res_trough,
	output logic signed [15:0] res_ov
);
	import wacs_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = 16 + CW;
	localparam int DW = SW;
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
	localparam logic [16:0] THIRD_RECIP = 17'd43691;

	logic [47:0] mem_q [WINDOW_DEPTH];
	logic [31:0] stamp_mem_q [WINDOW_DEPTH];
	logic [47:0] rd_q;
	logic [31:0] stamp_rd_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] scan_slot_q;
	logic [CW-1:0] scan_cnt_q;
	logic [31:0] now_q;
	logic signed [SW-1:0] sum_q [3];
	logic signed [15:0] mx_q [3];
	logic signed [15:0] mn_q [3];
	logic signed [15:0] peak_q;
	logic signed [15:0] trough_q;
	logic [DW-1:0] rem_q [3];
	logic [DW-1:0] quo_q [3];
	logic [DW-1:0] dvd_q [3];
	logic neg_q [3];
	logic [$clog2(DW+1)-1:0] dcnt_q;
	logic [16:0] ovquo_q;
	logic ovneg_q;
	logic [AW-1:0] ins_slot;
	logic [AW-1:0] oldest_adv;
	logic [AW-1:0] scan_next;
	logic [31:0] age;
	logic signed [17:0] msum;
	logic [16:0] ov_mag;
	logic [33:0] ov_prod;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = {{(CW+1-AW){1'b0}}, a} + {1'b0, k};
		if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
		return s[AW-1:0];
	endfunction

	assign oldest_adv = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
	assign scan_next = (scan_slot_q == LAST_SLOT) ? '0 : scan_slot_q + 1'b1;
	assign age = now_q - stamp_rd_q;

	always_comb begin
		if (fill_q >= DEPTH_C) ins_slot = oldest_q;
		else ins_slot = wrap_add(oldest_q, fill_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.write && sample_present) begin
			mem_q[ins_slot] <= {accel_x, accel_y, accel_z};
			stamp_mem_q[ins_slot] <= now_ms;
		end
		if (cmd.expire_rd) stamp_rd_q <= stamp_mem_q[oldest_q];
		if (cmd.scan_rd) rd_q <= mem_q[cmd.scan_first ? oldest_q : scan_slot_q];
	end

	assign sts.empty = (fill_q == '0);
	assign sts.expired = (age > {16'd0, window_ms});
	assign sts.scan_last = (scan_cnt_q == fill_q - 1'b1);
	assign sts.div_last = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q <= '0;
			peak_q <= -16'sd32768;
			trough_q <= 16'sd32767;
		end else begin
			if (cmd.write && sample_present) begin
				if (fill_q >= DEPTH_C) oldest_q <= oldest_adv;
				else fill_q <= fill_q + 1'b1;
			end
			if (cmd.expire_pop) begin
				oldest_q <= oldest_adv;
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.div_start && !sts.empty) begin
				if (mx_q[0] > peak_q && mx_q[0] >= mx_q[1] && mx_q[0] >= mx_q[2]) peak_q <= mx_q[0];
				else if (mx_q[1] > peak_q && mx_q[1] >= mx_q[2]) peak_q <= mx_q[1];
				else if (mx_q[2] > peak_q) peak_q <= mx_q[2];
				if (mn_q[0] < trough_q && mn_q[0] <= mn_q[1] && mn_q[0] <= mn_q[2]) trough_q <= mn_q[0];
				else if (mn_q[1] < trough_q && mn_q[1] <= mn_q[2]) trough_q <= mn_q[1];
				else if (mn_q[2] < trough_q) trough_q <= mn_q[2];
			end
		end
	end

	assign msum = (neg_q[0] ? -$signed({2'b0, quo_q[0][15:0]}) : $signed({2'b0, quo_q[0][15:0]}))
		+ (neg_q[1] ? -$signed({2'b0, quo_q[1][15:0]}) : $signed({2'b0, quo_q[1][15:0]}))
		+ (neg_q[2] ? -$signed({2'b0, quo_q[2][15:0]}) : $signed({2'b0, quo_q[2][15:0]}));

	// The magnitude stays below 2^17, where the reciprocal gives the exact quotient.
	assign ov_mag = msum[17] ? 17'(-msum) : 17'(msum);
	assign ov_prod = {17'd0, ov_mag} * {17'd0, THIRD_RECIP};

	always_ff @(posedge clk) begin
		logic signed [15:0] v [3];
		logic [DW:0] t;
		if (cmd.start) now_q <= now_ms;
		v[0] = $signed(rd_q[47:32]);
		v[1] = $signed(rd_q[31:16]);
		v[2] = $signed(rd_q[15:0]);
		if (cmd.scan_first) begin
			scan_slot_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
			scan_cnt_q <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
				mx_q[a] <= -16'sd32768;
				mn_q[a] <= 16'sd32767;
			end
		end
		if (cmd.scan_acc) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
			if (cmd.scan_rd) scan_slot_q <= scan_next;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= sum_q[a] + SW'(v[a]);
				if (v[a] > mx_q[a]) mx_q[a] <= v[a];
				if (v[a] < mn_q[a]) mn_q[a] <= v[a];
			end
		end
		if (cmd.div_start) begin
			dcnt_q <= ($clog2(DW+1))'(DW - 1);
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= !sts.empty && sum_q[a][SW-1];
				dvd_q[a] <= sts.empty ? '0 : (sum_q[a][SW-1] ? DW'(-sum_q[a]) : DW'(sum_q[a]));
				rem_q[a] <= '0;
				quo_q[a] <= '0;
				if (sts.empty) begin
					mx_q[a] <= '0;
					mn_q[a] <= '0;
				end
			end
		end
		if (cmd.div_step) begin
			if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
			for (int a = 0; a < 3; a++) begin
				t = {rem_q[a], dvd_q[a][DW-1]};
				if (fill_q != '0 && t >= (DW+1)'(fill_q)) begin
					rem_q[a] <= DW'(t - (DW+1)'(fill_q));
					quo_q[a] <= {quo_q[a][DW-2:0], 1'b1};
				end else begin
					rem_q[a] <= DW'(t);
					quo_q[a] <= {quo_q[a][DW-2:0], 1'b0};
				end
				dvd_q[a] <= {dvd_q[a][DW-2:0], 1'b0};
			end
		end
		if (cmd.ov_step) begin
			ovneg_q <= msum[17];
			ovquo_q <= ov_prod[33:17];
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			res_mean[a] = neg_q[a] ? -$signed(quo_q[a][15:0]) : $signed(quo_q[a][15:0]);
			res_max[a] = mx_q[a];
			res_min[a] = mn_q[a];
		end
		res_peak = peak_q;
		res_trough = trough_q;
		res_ov = ovneg_q ? -$signed(ovquo_q[15:0]) : $signed(ovquo_q[15:0]);
	end
endmodule

// ===== rtl/windowed_accel_statistics_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_accel_statistics_top: sliding window accelerometer statistics
// Each item appends an optional sample, expires old entries and reports the
// window mean, maximum and minimum per axis with running extremes and the
// overall mean. Expired entries and the remaining fill are read one at a time
// through the single store read port, and the means come from bit-serial
// dividers; the next item is taken once the result appears. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module windowed_accel_statistics_top #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        now_ms,
	input  logic               sample_present,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] mean_x,
	output logic signed [15:0] mean_y,
	output logic signed [15:0] mean_z,
	output logic signed [15:0] max_x,
	output logic signed [15:0] max_y,
	output logic signed [15:0] max_z,
	output logic signed [15:0] min_x,
	output logic signed [15:0] min_y,
	output logic signed [15:0] min_z,
	output logic signed [15:0] peak_overall,
	output logic signed [15:0] trough_overall,
	output logic signed [15:0] mean_overall
);
	import wacs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;
	logic [15:0] window_q;
	logic signed [15:0] r_mean [3];
	logic signed [15:0] r_max [3];
	logic signed [15:0] r_min [3];
	logic signed [15:0] r_peak;
	logic signed [15:0] r_trough;
	logic signed [15:0] r_ov;

	assign in_ready = idle;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= WINDOW_RESET;
		else if (cfg_valid) window_q <= cfg_data;
	end

	wacs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && in_ready),
		.out_busy(out_valid && !out_ready), .sts(sts), .cmd(cmd), .idle(idle)
	);

	wacs_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .window_ms(window_q),
		.now_ms(now_ms), .sample_present(sample_present), .accel_x(accel_x),
		.accel_y(accel_y), .accel_z(accel_z), .res_mean(r_mean), .res_max(r_max),
		.res_min(r_min), .res_peak(r_peak), .res_trough(r_trough), .res_ov(r_ov)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.finish) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mean_x <= r_mean[0];
			mean_y <= r_mean[1];
			mean_z <= r_mean[2];
			max_x <= r_max[0];
			max_y <= r_max[1];
			max_z <= r_max[2];
			min_x <= r_min[0];
			min_y <= r_min[1];
			min_z <= r_min[2];
			peak_overall <= r_peak;
			trough_overall <= r_trough;
			mean_overall <= r_ov;
		end
	end
endmodule

// ===== rtl/wacs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacs_checker: port level checks for the statistics block
// Watches the handshakes and result ordering at the top level ports.
// ----------------------------------------------------------------------------
module wacs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] peak_overall,
	input logic signed [15:0] trough_overall,
	input logic signed [15:0] mean_x,
	input logic signed [15:0] max_x,
	input logic signed [15:0] min_x
);
	a_no_accept_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mean_x))) else $error("result dropped");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_x <= max_x)) else $error("window minimum above maximum");
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid) && !$stable(peak_overall)) |-> (peak_overall > $past(peak_overall)))
		else $error("peak decreased");
	a_trough_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid) && !$stable(trough_overall))
		|-> (trough_overall < $past(trough_overall)))
		else $error("trough increased");
endmodule

bind windowed_accel_statistics_top wacs_checker u_wacs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .peak_overall(peak_overall),
	.trough_overall(trough_overall), .mean_x(mean_x), .max_x(max_x), .min_x(min_x)
);
